// ----- design/esd_pkg.sv -----
// Package for the escape sequence decoder: decode modes, character codes,
// item and result types, and the octal and hex digit helpers. No dependencies.
package esd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_OCT    = 3'd4
  } mode_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       string_end;
    logic       run_last;
  } res_t;

  // results produced by one item, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // digit value, or HEX_NONE when c is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = {1'b0, c[3:0]};
    end else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF))) begin
      v = {1'b0, c[3:0]} + 5'd9;
    end
    return v;
  endfunction

endpackage

// ----- design/esd_if.sv -----
// Valid/ready channel interfaces for the escape sequence decoder.
// Input beats carry a source character, output beats carry one result.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output out_valid, output string_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input out_valid, input string_end,
                input run_last, output ready);
endinterface

// ----- design/escape_sequence_decoder_core.sv -----
// Escape sequence decoder, top level: input register, decode, result queue.
// The input register holds a character while the result queue cannot take
// its results, and the queue holds results until the output takes them.
// Throughput: one character per cycle while each gives at most one result and
// results are taken every cycle; a two-result character holds the output for
// two beats. Reset (rst_ni, async, active low) empties both stages and returns
// the decoder to normal mode with its octal and hex registers cleared.
module escape_sequence_decoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  esd_in_if.sink    in_i,
  esd_out_if.source out_o
);
  import esd_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  take;
  logic  consume;
  dec_t  dec;
  res_t  res;

  assign in_item.in_byte  = in_i.in_byte;
  assign in_item.in_final = in_i.in_final;
  assign consume          = item_valid && take;

  esd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .item_i       (in_item),
    .consume_i    (consume),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  esd_decode u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .consume_i (consume),
    .dec_o     (dec)
  );

  esd_out_queue u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dec_i   (dec),
    .load_i  (consume),
    .take_o  (take),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.out_byte   = res.out_byte;
  assign out_o.out_valid  = res.out_valid;
  assign out_o.string_end = res.string_end;
  assign out_o.run_last   = res.run_last;

endmodule

// ----- design/esd_in_stage.sv -----
// Input register of the escape sequence decoder: holds one accepted beat
// until the decoder consumes it. Depends on esd_pkg.
module esd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  esd_pkg::item_t item_i,
  input  logic          consume_i,
  output logic          item_valid_o,
  output esd_pkg::item_t item_o
);
  import esd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || consume_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- design/esd_decode.sv -----
// Escape decode state machine: mode, octal and hex registers, and the up to
// two results of the held character. Depends on esd_pkg.
module esd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  esd_pkg::item_t item_i,
  input  logic           consume_i,
  output esd_pkg::dec_t  dec_o
);
  import esd_pkg::*;

  mode_e      mode_q, mode_d, mode_n;
  logic [8:0] ov_q, ov_d, ov_n;
  logic [1:0] od_q, od_d, od_n;
  logic [7:0] hf_q, hf_d, hf_n;

  logic [7:0] c;
  logic       fin;
  logic       c_oct;
  logic [4:0] h1, h2;
  logic [7:0] hex_byte;
  logic [7:0] b0, b1;
  logic [1:0] n;

  assign c     = item_i.in_byte;
  assign fin   = item_i.in_final;
  assign c_oct = is_octal(c);
  assign h1    = hex_val(hf_q);
  assign h2    = hex_val(c);

  always_comb begin
    if (h1 == HEX_NONE) begin
      hex_byte = 8'd0;
    end else if (h2 == HEX_NONE) begin
      hex_byte = {4'd0, h1[3:0]};
    end else begin
      hex_byte = {h1[3:0], h2[3:0]};
    end
  end

  // next state
  always_comb begin
    mode_n = mode_q;
    ov_n   = ov_q;
    od_n   = od_q;
    hf_n   = hf_q;
    unique case (mode_q)
      MODE_ESC: begin
        if (c == CH_X) begin
          mode_n = MODE_HEX1;
        end else if (c_oct) begin
          ov_n   = {6'd0, c[2:0]};
          od_n   = 2'd1;
          mode_n = MODE_OCT;
        end else begin
          mode_n = MODE_NORMAL;
        end
      end
      MODE_HEX1: begin
        hf_n   = c;
        mode_n = MODE_HEX2;
      end
      MODE_HEX2: begin
        mode_n = MODE_NORMAL;
      end
      MODE_OCT: begin
        if (c_oct && (od_q != 2'd2)) begin
          ov_n = {ov_q[5:0], c[2:0]};
          od_n = od_q + 2'd1;
        end else begin
          ov_n = 9'd0;
          od_n = 2'd0;
          if (!c_oct && (c == CH_BSLASH)) begin
            mode_n = MODE_ESC;
          end else begin
            mode_n = MODE_NORMAL;
          end
        end
      end
      default: begin
        mode_n = (c == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
      end
    endcase
  end

  always_comb begin
    if (fin) begin
      mode_d = MODE_NORMAL;
      ov_d   = 9'd0;
      od_d   = 2'd0;
      hf_d   = 8'd0;
    end else begin
      mode_d = mode_n;
      ov_d   = ov_n;
      od_d   = od_n;
      hf_d   = hf_n;
    end
  end

  // emitted bytes
  always_comb begin
    b0 = c;
    b1 = c;
    n  = 2'd0;
    unique case (mode_q)
      MODE_ESC: begin
        if ((c != CH_X) && !c_oct) begin
          n = 2'd1;
        end
      end
      MODE_HEX1: begin
        n = 2'd0;
      end
      MODE_HEX2: begin
        b0 = hex_byte;
        n  = 2'd1;
      end
      MODE_OCT: begin
        if (c_oct) begin
          if (od_q == 2'd2) begin
            b0 = {ov_q[4:0], c[2:0]};
            n  = 2'd1;
          end
        end else begin
          b0 = ov_q[7:0];
          n  = (c == CH_BSLASH) ? 2'd1 : 2'd2;
        end
      end
      default: begin
        if (c != CH_BSLASH) begin
          n = 2'd1;
        end
      end
    endcase
    if (fin && (mode_n == MODE_OCT)) begin
      b0 = ov_n[7:0];
      n  = 2'd1;
    end
  end

  always_comb begin
    dec_o.r0.out_byte   = b0;
    dec_o.r0.out_valid  = 1'b1;
    dec_o.r0.run_last   = (n == 2'd1);
    dec_o.r0.string_end = fin && (n == 2'd1);
    dec_o.r1.out_byte   = b1;
    dec_o.r1.out_valid  = 1'b1;
    dec_o.r1.run_last   = 1'b1;
    dec_o.r1.string_end = fin;
    dec_o.cnt           = n;
    if (fin && (n == 2'd0)) begin
      // string closed with nothing decoded: a bare end marker
      dec_o.r0.out_byte  = 8'd0;
      dec_o.r0.out_valid = 1'b0;
      dec_o.r0.run_last  = 1'b1;
      dec_o.r0.string_end = 1'b1;
      dec_o.cnt          = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      ov_q   <= 9'd0;
      od_q   <= 2'd0;
      hf_q   <= 8'd0;
    end else if (consume_i) begin
      mode_q <= mode_d;
      ov_q   <= ov_d;
      od_q   <= od_d;
      hf_q   <= hf_d;
    end
  end

  a_oct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OCT) |-> ((od_q == 2'd1) || (od_q == 2'd2)))
    else $error("octal digit count out of range in octal mode");

  a_oct_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_OCT) |-> ((od_q == 2'd0) && (ov_q == 9'd0)))
    else $error("octal registers not cleared outside octal mode");

  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume_i && item_i.in_final) |=> ((mode_q == MODE_NORMAL) && (hf_q == 8'd0)))
    else $error("state not cleared after final character");

endmodule

// ----- design/esd_out_queue.sv -----
// Two-slot result register of the escape sequence decoder; takes the
// results of one character at once and hands them out one beat at a time.
// Depends on esd_pkg.
module esd_out_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  esd_pkg::dec_t dec_i,
  input  logic          load_i,
  output logic          take_o,
  output logic          valid_o,
  input  logic          ready_i,
  output esd_pkg::res_t res_o
);
  import esd_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  res_t       q0_q, q0_d, q1_q, q1_d;
  logic       pop;
  logic [1:0] rem;
  logic [2:0] total;

  assign pop    = (cnt_q != 2'd0) && ready_i;
  assign rem    = cnt_q - {1'b0, pop};
  assign total  = {1'b0, rem} + {1'b0, dec_i.cnt};
  assign take_o = (total <= 3'd2);

  always_comb begin
    q0_d  = q0_q;
    q1_d  = q1_q;
    cnt_d = rem;
    if (pop) begin
      q0_d = q1_q;
    end
    if (load_i) begin
      cnt_d = total[1:0];
      case (rem)
        2'd0: begin
          q0_d = dec_i.r0;
          q1_d = dec_i.r1;
        end
        2'd1: begin
          q1_d = dec_i.r0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = q0_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overfilled");

endmodule

// ----- dv/esd_checker.sv -----
// Checker for escape_sequence_decoder_core: watches the character and result channels,
// decodes each accepted character on its own and compares the results in order.
// Depends on esd_pkg and the esd_in_if / esd_out_if interfaces.
module esd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  esd_in_if    in_mon,
  esd_out_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  import esd_pkg::*;

  mode_e      mode_q;
  logic [8:0] oct_acc_q;
  logic [1:0] oct_cnt_q;
  logic [7:0] hex_hi_q;
  res_t       decoded_q[$];

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return 5'(c - CH_ZERO);
    if ((c >= CH_LA) && (c <= CH_LF)) return 5'(c - CH_LA) + 5'd10;
    if ((c >= CH_UA) && (c <= CH_UF)) return 5'(c - CH_UA) + 5'd10;
    return HEX_NONE;
  endfunction

  function automatic logic octal_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log bounded on a badly broken block
    if (fail_cnt_o < 200) $display("%0t: mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  task automatic clear_decoder();
    mode_q    = MODE_NORMAL;
    oct_acc_q = '0;
    oct_cnt_q = '0;
    hex_hi_q  = '0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic is_end);
    logic [7:0] dec [2];
    int         n;
    logic       plain;
    logic [4:0] h1;
    logic [4:0] h2;
    res_t       r;
    n     = 0;
    plain = 1'b0;
    case (mode_q)
      MODE_ESC: begin
        mode_q = MODE_NORMAL;
        if (c == CH_X) begin
          mode_q = MODE_HEX1;
        end else if (octal_char(c)) begin
          oct_acc_q = {6'd0, c[2:0]};
          oct_cnt_q = 2'd1;
          mode_q    = MODE_OCT;
        end else begin
          dec[n] = c;
          n++;
        end
      end
      MODE_HEX1: begin
        hex_hi_q = c;
        mode_q   = MODE_HEX2;
      end
      MODE_HEX2: begin
        h1 = hex_digit(hex_hi_q);
        h2 = hex_digit(c);
        if (h1 > 5'd15) dec[n] = 8'd0;
        else if (h2 > 5'd15) dec[n] = {4'd0, h1[3:0]};
        else dec[n] = {h1[3:0], h2[3:0]};
        n++;
        mode_q = MODE_NORMAL;
      end
      MODE_OCT: begin
        if (octal_char(c)) begin
          oct_acc_q = {oct_acc_q[5:0], c[2:0]};
          oct_cnt_q = oct_cnt_q + 2'd1;
          if (oct_cnt_q == 2'd3) begin
            dec[n] = oct_acc_q[7:0];
            n++;
            clear_decoder();
          end
        end else begin
          dec[n] = oct_acc_q[7:0];
          n++;
          clear_decoder();
          plain = 1'b1;
        end
      end
      default: begin
        mode_q = MODE_NORMAL;
        plain  = 1'b1;
      end
    endcase
    if (plain) begin
      if (c == CH_BSLASH) begin
        mode_q = MODE_ESC;
      end else begin
        dec[n] = c;
        n++;
      end
    end
    if (is_end) begin
      if (mode_q == MODE_OCT) begin
        dec[n] = oct_acc_q[7:0];
        n++;
      end
      clear_decoder();
    end
    if (n == 0) begin
      if (is_end) begin
        r = '{out_byte: 8'd0, out_valid: 1'b0, string_end: 1'b1, run_last: 1'b1};
        decoded_q.push_back(r);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte   = dec[k];
        r.out_valid  = 1'b1;
        r.string_end = is_end && (k == n - 1);
        r.run_last   = (k == n - 1);
        decoded_q.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    res_t e;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat, out_byte %02h", out_mon.out_byte));
    end else begin
      e = decoded_q.pop_front();
      if (out_mon.out_byte !== e.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_mon.out_byte, e.out_byte));
      if (out_mon.out_valid !== e.out_valid)
        report_mismatch($sformatf("out_valid %b, expected %b", out_mon.out_valid, e.out_valid));
      if (out_mon.string_end !== e.string_end)
        report_mismatch($sformatf("string_end %b, expected %b", out_mon.string_end,
                                  e.string_end));
      if (out_mon.run_last !== e.run_last)
        report_mismatch($sformatf("run_last %b, expected %b", out_mon.run_last, e.run_last));
    end
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
      decoded_q.delete();
      pending_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) decode_char(in_mon.in_byte, in_mon.in_final);
      if (out_mon.valid && out_mon.ready) check_result();
      pending_o = decoded_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Top of the escape_sequence_decoder_core testbench: clock, reset, character stimulus
// (directed escapes, then random strings) and result back-pressure; gives the verdict.
// Depends on esd_pkg, the channel interfaces, the core and esd_checker.
module tb;
  import esd_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   sent;
  int   idle_pct;
  int   stall_pct;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  esd_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("escape_sequence_decoder_core test failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = any_char(); while (c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] hex_or_any();
    int r;
    r = $urandom_range(0, 26);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_LA + 8'(r - 10);
    if (r < 22) return CH_UA + 8'(r - 16);
    return any_char();
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_end);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= c;
    in_ch.in_final <= is_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_str(input logic [7:0] s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  // hold the sender until every pending result has been seen
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly well-formed escapes with random content, some noise, some cut short
  task automatic rand_string(output logic [7:0] s[$]);
    int ntok;
    int nd;
    s = {};
    ntok = $urandom_range(1, 12);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: s.push_back(plain_char());
        3: begin
          s.push_back(CH_BSLASH);
          s.push_back(CH_BSLASH);
        end
        4, 5: begin
          s.push_back(CH_BSLASH);
          s.push_back(CH_X);
          s.push_back(hex_or_any());
          s.push_back(hex_or_any());
        end
        6, 7: begin
          s.push_back(CH_BSLASH);
          nd = $urandom_range(1, 3);
          repeat (nd) s.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
        8: begin
          s.push_back(CH_BSLASH);
          s.push_back(any_char());
        end
        default: s.push_back(any_char());
      endcase
    end
    if ($urandom_range(0, 4) == 0) s = s[0:$urandom_range(0, s.size() - 1)];
  endtask

  task automatic run_phase(input int n_items, input int idle, input int stall);
    logic [7:0] s[$];
    int         target;
    drain();
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent + n_items;
    while (sent < target) begin
      rand_string(s);
      send_str(s);
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] s[$];
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'd0;
    in_ch.in_final  = 1'b0;
    out_ch.ready    = 1'b0;
    sent            = 0;
    idle_pct        = 14;
    stall_pct       = 53;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // escaped backslash, escaped other char, full hex escape
    s = '{CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h01, CH_BSLASH, CH_X, CH_LF, CH_UF};
    send_str(s);
    // bad first hex char, bad second hex char, octal overflow, octal cut by a char
    s = '{CH_BSLASH, CH_X, 8'hFF, CH_ZERO + 8'd1, CH_BSLASH, CH_X, CH_UA, 8'hFF,
          CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN, CH_BSLASH, CH_ZERO + 8'd1, CH_NINE};
    send_str(s);
    // octal at string end, lone backslash at end, incomplete hex at end
    s = '{CH_BSLASH, CH_ZERO + 8'd5};
    send_str(s);
    s = '{CH_BSLASH};
    send_str(s);
    s = '{CH_BSLASH, CH_X};
    send_str(s);

    run_phase(550, 14, 53);
    run_phase(550, 53, 14);
    run_phase(550, 0, 0);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("escape_sequence_decoder_core test passed");
    end else begin
      $display("escape_sequence_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/esd_pkg.sv
design/esd_if.sv
design/esd_in_stage.sv
design/esd_decode.sv
design/esd_out_queue.sv
design/escape_sequence_decoder_core.sv
dv/esd_checker.sv
dv/tb.sv
